// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros
// assertion macros for the rtl core
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/core/lpht_pkg.sv -----
// ----------------------------------------------------------------------------
// lpht_pkg
// shared types, codes and the key mixer constants of the hash table core
// ----------------------------------------------------------------------------
package lpht_pkg;
   localparam int SLOTS      = 1024;
   localparam int SLOT_BITS  = $clog2(SLOTS);
   localparam int VALUE_BITS = 32;
   localparam int KEY_BITS   = 64;
   localparam int CNT_BITS   = SLOT_BITS + 1;

   typedef logic [SLOT_BITS-1:0]  slot_type;
   typedef logic [CNT_BITS-1:0]   count_type;
   typedef logic [KEY_BITS-1:0]   key_type;
   typedef logic [VALUE_BITS-1:0] value_type;

   localparam logic [2:0] KIND_SET   = 3'd0;
   localparam logic [2:0] KIND_GET   = 3'd1;
   localparam logic [2:0] KIND_DEL   = 3'd2;
   localparam logic [2:0] KIND_GOC   = 3'd3;
   localparam logic [2:0] KIND_CLEAR = 3'd4;

   localparam logic [2:0] ST_FOUND    = 3'd0;
   localparam logic [2:0] ST_INSERTED = 3'd1;
   localparam logic [2:0] ST_MISSING  = 3'd2;
   localparam logic [2:0] ST_RESERVED = 3'd3;
   localparam logic [2:0] ST_FULL     = 3'd4;

   localparam logic [1:0] REG_RESERVED = 2'd0;
   localparam logic [1:0] REG_BYPASS   = 2'd1;
   localparam logic [1:0] REG_MAX      = 2'd2;

   localparam logic [63:0] MIX_ADD = 64'h9e3779b97f4a7c15;
   localparam logic [63:0] MIX_M1  = 64'hbf58476d1ce4e5b9;
   localparam logic [63:0] MIX_M2  = 64'h94d049bb133111eb;
endpackage

// ----- rtl/core/lpht_ram.sv -----
// ----------------------------------------------------------------------------
// lpht_ram
// single port synchronous ram with registered read
// ----------------------------------------------------------------------------
module lpht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule

// ----- rtl/core/linear_probe_hash_table_core.sv -----
// ----------------------------------------------------------------------------
// linear_probe_hash_table_core
// open-addressing key/value table with linear probing and backward-shift delete
// ----------------------------------------------------------------------------
// One request item gives one response item. Every slot lives in one ram word
// {occupied, value, key} read through a registered port, so no slot state sits
// in flip-flops. After reset a clearing pass writes every slot empty (req_tready
// low); a clear item runs the same pass. A request hashes its key with a 64-bit
// mixer built from 32x32 partial products (skipped in bypass mode), then checks
// one slot per cycle until a key match, a free slot or a full lap. Delete then
// rehashes each following entry (no hash in bypass) and moves it back into the
// hole when its probe distance allows, until an empty slot or a full lap ends
// the shift and the last hole is emptied. Reserved keys and unknown kinds go
// straight to the response. The response waits in an output register with its
// own copy of the entry total; a new request is accepted while it is unread,
// and that request stalls at its own response until the old one is taken.
module linear_probe_hash_table_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [2:0]  req_tuser,   // kind
   input  logic [95:0] req_tdata,   // key [63:0], value [95:64]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // status [2:0], value_out [34:3], entry_total [45:35]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data
);
   import lpht_pkg::*;
`include "assert_macros.svh"

   typedef enum logic [9:0] {
      S_CLR   = 10'b0000000001,
      S_IDLE  = 10'b0000000010,
      S_HASH  = 10'b0000000100,
      S_RD    = 10'b0000001000,
      S_CHK   = 10'b0000010000,
      S_DRD   = 10'b0000100000,
      S_DCHK  = 10'b0001000000,
      S_DHASH = 10'b0010000000,
      S_DMOVE = 10'b0100000000,
      S_DONE  = 10'b1000000000
   } state_type;

   // configuration
   key_type   rkey_ff;
   logic      bypass_ff;
   logic [9:0] maxe_ff;

   state_type state_ff, state_in;
   count_type count_ff;
   slot_type  clr_ff;       // clearing pass address
   logic      clr_rsp_ff;   // pass belongs to a clear item

   logic [2:0] kind_ff;
   key_type    key_ff;
   value_type  val_ff;
   slot_type   ptr_ff;      // probe pointer
   slot_type   hole_ff;     // delete hole
   count_type  steps_ff;    // probe steps taken
   // hash unit
   logic [3:0]  hstep_ff;
   logic [63:0] hx_ff, hacc_ff;
   logic        hcur_ff;    // 0: request key, 1: entry key
   // moved entry holding
   key_type     mkey_ff;
   value_type   mval_ff;
   // result of the item in work
   logic [2:0]  wstat_ff;
   value_type   wval_ff;

   // response register
   logic        rvalid_ff;
   logic [2:0]  rstat_ff;
   value_type   rval_ff;
   count_type   rcnt_ff;

   // ram port, word is {occupied, value, key}
   logic        ram_we;
   slot_type    ram_addr;
   logic [KEY_BITS+VALUE_BITS:0] ram_wd, ram_rd;

   lpht_ram #(.WIDTH(KEY_BITS + VALUE_BITS + 1), .DEPTH(SLOTS)) u_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .addr   (ram_addr),
      .wr_data(ram_wd),
      .rd_data(ram_rd)
   );

   key_type   rd_key;
   value_type rd_val;
   logic      rd_ok;
   assign rd_key = ram_rd[KEY_BITS-1:0];
   assign rd_val = ram_rd[KEY_BITS+VALUE_BITS-1:KEY_BITS];
   assign rd_ok  = ram_rd[KEY_BITS+VALUE_BITS];

   key_type   req_key;
   value_type req_val;
   assign req_key = req_tdata[63:0];
   assign req_val = req_tdata[95:64];

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata  = {2'b00, rcnt_ff, rval_ff, rstat_ff};

   logic req_fire;
   assign req_fire = req_tvalid && req_tready;

   // response register free for the finished item
   logic rsp_load;
   assign rsp_load = (state_ff == S_DONE) && (!rvalid_ff || rsp_tready);

   // mixer partial products: 32x32 each, one per cycle
   logic [31:0] pa, pb;
   logic [63:0] pprod;
   assign pprod = pa * pb;

   // hash schedule: step 0 add, 1 xorshift30, 2..5 mul m1 (3 products),
   // 6 xorshift27, 7..10 mul m2, 11 xorshift31 and done
   logic [63:0] hmul_c;
   always_comb begin
      hmul_c = (hstep_ff < 4'd6) ? MIX_M1 : MIX_M2;
      pa = 32'd0;
      pb = 32'd0;
      case (hstep_ff)
         4'd2, 4'd7: begin pa = hx_ff[31:0];  pb = hmul_c[31:0];  end
         4'd3, 4'd8: begin pa = hx_ff[31:0];  pb = hmul_c[63:32]; end
         4'd4, 4'd9: begin pa = hx_ff[63:32]; pb = hmul_c[31:0];  end
         default: begin pa = 32'd0; pb = 32'd0; end
      endcase
   end

   // probe distance compare for backward shift
   slot_type d_hole, d_si;
   assign d_hole = hole_ff - hx_ff[SLOT_BITS-1:0];
   assign d_si   = ptr_ff  - hx_ff[SLOT_BITS-1:0];

   logic do_move;
   assign do_move = (d_hole <= d_si);

   logic at_limit;
   assign at_limit = ({1'b0, count_ff} >= {2'b00, maxe_ff});

   logic is_lookup;
   assign is_lookup = (kind_ff == KIND_GET) || (kind_ff == KIND_DEL);

   logic hash_done;
   assign hash_done = (hstep_ff == 4'd11);

   logic chk_last;
   assign chk_last = (steps_ff == count_type'(SLOTS - 1));

   logic dchk_stop;
   assign dchk_stop = !rd_ok || (steps_ff == count_type'(SLOTS));

   always_comb begin
      state_in = state_ff;
      ram_we   = 1'b0;
      ram_addr = ptr_ff;
      ram_wd   = {1'b1, val_ff, key_ff};
      case (state_ff)
         S_CLR: begin
            ram_we   = 1'b1;
            ram_addr = clr_ff;
            ram_wd   = '0;
            if (clr_ff == slot_type'(SLOTS - 1)) state_in = clr_rsp_ff ? S_DONE : S_IDLE;
         end
         S_IDLE: begin
            if (req_fire) begin
               if (req_tuser == KIND_CLEAR) state_in = S_CLR;
               else if (req_tuser > KIND_CLEAR || req_key == rkey_ff) state_in = S_DONE;
               else if (bypass_ff) state_in = S_RD;
               else state_in = S_HASH;
            end
         end
         S_HASH:  if (hash_done) state_in = hcur_ff ? S_DMOVE : S_RD;
         S_RD:    state_in = S_CHK;
         S_CHK: begin
            if (!rd_ok) begin
               // free slot: a lookup misses, otherwise insert a new key below the limit
               ram_we   = !is_lookup && !at_limit;
               state_in = S_DONE;
            end else if (rd_key == key_ff) begin
               ram_we   = (kind_ff == KIND_SET);
               state_in = (kind_ff == KIND_DEL) ? S_DRD : S_DONE;
            end else if (chk_last) begin
               state_in = S_DONE;
            end else begin
               // read the next slot while this one is passed
               ram_addr = ptr_ff + slot_type'(1);
            end
         end
         S_DRD:   state_in = S_DCHK;
         S_DCHK: begin
            if (dchk_stop) begin
               // empty the last hole
               ram_we   = 1'b1;
               ram_addr = hole_ff;
               ram_wd   = '0;
               state_in = S_DONE;
            end else begin
               state_in = bypass_ff ? S_DHASH : S_HASH;
            end
         end
         S_DHASH: state_in = S_DMOVE;
         S_DMOVE: begin
            if (do_move) begin
               ram_we   = 1'b1;
               ram_addr = hole_ff;
               ram_wd   = {1'b1, mval_ff, mkey_ff};
            end
            state_in = S_DRD;
         end
         S_DONE:  if (rsp_load) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLR;
         clr_ff     <= '0;
         clr_rsp_ff <= 1'b0;
         count_ff   <= '0;
         rvalid_ff  <= 1'b0;
         rkey_ff    <= '0;
         bypass_ff  <= 1'b0;
         maxe_ff    <= 10'd615;
         hstep_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_valid) begin
            case (csr_index)
               REG_RESERVED: rkey_ff   <= csr_data;
               REG_BYPASS:   bypass_ff <= csr_data[0];
               REG_MAX:      maxe_ff   <= csr_data[9:0];
               default: ;
            endcase
         end
         if (rsp_load) begin
            rvalid_ff <= 1'b1;
            rstat_ff  <= wstat_ff;
            rval_ff   <= wval_ff;
            rcnt_ff   <= count_ff;
         end else if (rsp_tready) begin
            rvalid_ff <= 1'b0;
         end

         case (state_ff)
            S_CLR: clr_ff <= clr_ff + slot_type'(1);
            S_IDLE: begin
               if (req_fire) begin
                  kind_ff    <= req_tuser;
                  key_ff     <= req_key;
                  val_ff     <= req_val;
                  hcur_ff    <= 1'b0;
                  hx_ff      <= req_key;
                  hstep_ff   <= '0;
                  steps_ff   <= '0;
                  wval_ff    <= '0;
                  wstat_ff   <= ST_MISSING;
                  clr_rsp_ff <= 1'b1;
                  if (req_tuser == KIND_CLEAR) begin
                     count_ff <= '0;
                     wstat_ff <= ST_FOUND;
                  end else if (req_tuser > KIND_CLEAR) begin
                     wstat_ff <= ST_MISSING;
                  end else if (req_key == rkey_ff) begin
                     wstat_ff <= ST_RESERVED;
                  end else if (bypass_ff) begin
                     ptr_ff <= req_key[SLOT_BITS-1:0];
                  end
               end
            end
            S_HASH: begin
               hstep_ff <= hstep_ff + 4'd1;
               case (hstep_ff)
                  4'd0: hx_ff <= hx_ff + MIX_ADD;
                  4'd1: hx_ff <= hx_ff ^ (hx_ff >> 30);
                  4'd2, 4'd7: hacc_ff <= pprod;
                  4'd3, 4'd8: hacc_ff <= hacc_ff + {pprod[31:0], 32'd0};
                  4'd4, 4'd9: hacc_ff <= hacc_ff + {pprod[31:0], 32'd0};
                  4'd5, 4'd10: hx_ff <= hacc_ff;
                  4'd6: hx_ff <= hx_ff ^ (hx_ff >> 27);
                  4'd11: begin
                     hx_ff <= hx_ff ^ (hx_ff >> 31);
                     if (!hcur_ff) ptr_ff <= hx_ff[SLOT_BITS-1:0]
                        ^ hx_ff[SLOT_BITS+30:31];
                  end
                  default: ;
               endcase
            end
            S_CHK: begin
               if (!rd_ok) begin
                  if (is_lookup) begin
                     wstat_ff <= ST_MISSING;
                  end else if (!at_limit) begin
                     count_ff <= count_ff + count_type'(1);
                     wstat_ff <= ST_INSERTED;
                     wval_ff  <= val_ff;
                  end else begin
                     wstat_ff <= ST_FULL;
                  end
               end else if (rd_key == key_ff) begin
                  wstat_ff <= ST_FOUND;
                  wval_ff  <= (kind_ff == KIND_SET) ? val_ff : rd_val;
                  if (kind_ff == KIND_DEL) begin
                     hole_ff  <= ptr_ff;
                     ptr_ff   <= ptr_ff + slot_type'(1);
                     steps_ff <= count_type'(1);
                  end
               end else if (chk_last) begin
                  wstat_ff <= is_lookup ? ST_MISSING : ST_FULL;
               end else begin
                  ptr_ff   <= ptr_ff + slot_type'(1);
                  steps_ff <= steps_ff + count_type'(1);
               end
            end
            S_DCHK: begin
               if (dchk_stop) begin
                  if (count_ff != '0) count_ff <= count_ff - count_type'(1);
               end else begin
                  mkey_ff  <= rd_key;
                  mval_ff  <= rd_val;
                  hx_ff    <= rd_key;
                  hcur_ff  <= 1'b1;
                  hstep_ff <= '0;
               end
            end
            S_DMOVE: begin
               if (do_move) hole_ff <= ptr_ff;
               ptr_ff   <= ptr_ff + slot_type'(1);
               steps_ff <= steps_ff + count_type'(1);
            end
            default: ;
         endcase
      end
   end

   `ASSERT_NEXT(a_done_rsp, clock, reset, state_ff == S_DONE, rvalid_ff)
   `ASSERT_IMPLIES(a_no_req_busy, clock, reset, state_ff != S_IDLE, !req_tready)
   `ASSERT_IMPLIES(a_cnt_range, clock, reset, 1'b1, count_ff <= count_type'(SLOTS))
   `ASSERT_IMPLIES(a_we_busy, clock, reset, ram_we, state_ff != S_IDLE)
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rvalid_ff && !rsp_tready, rvalid_ff)
endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives request items into the hash table core, predicts every response
// with a software table of its own and checks each response field by field
// ----------------------------------------------------------------------------
module testbench;
   import lpht_pkg::*;

   localparam int WATCHDOG_LIMIT = 200000;

   // first field in the top bits, so status lands in the low bits
   typedef struct packed {
      logic [10:0] entry_total;
      logic [31:0] value_out;
      logic [2:0]  status;
   } table_reply_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [2:0]  req_tuser;   // kind
   logic [95:0] req_tdata;   // key [63:0], value [95:64]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;   // status [2:0], value_out [34:3], entry_total [45:35]
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [63:0] csr_data;

   linear_probe_hash_table_core dut (.*);

   // shadow table
   bit          shadow_valid [SLOTS];
   logic [63:0] shadow_key [SLOTS];
   logic [31:0] shadow_val [SLOTS];
   int          shadow_count;
   logic [63:0] cfg_reserved;
   bit          cfg_bypass;
   int          cfg_max;

   table_reply_type replies_due [$];
   int  fail_count;
   int  idle_pct;
   int  idle_cycles;
   logic [63:0] key_pool [$];

   always begin
      clock = 1'b0; #10;
      clock = 1'b1; #10;
   end

   function automatic int home_slot(logic [63:0] k);
      logic [63:0] x;
      if (cfg_bypass) return int'(k[SLOT_BITS-1:0]);
      x = k + 64'h9e3779b97f4a7c15;
      x = (x ^ (x >> 30)) * 64'hbf58476d1ce4e5b9;
      x = (x ^ (x >> 27)) * 64'h94d049bb133111eb;
      x = x ^ (x >> 31);
      return int'(x[SLOT_BITS-1:0]);
   endfunction

   // 1 key hit, 0 free slot, -1 neither
   function automatic int find_slot(logic [63:0] k, output int where);
      int b;
      int s;
      b = home_slot(k);
      where = 0;
      for (int i = 0; i < SLOTS; i++) begin
         s = (b + i) % SLOTS;
         if (!shadow_valid[s]) begin where = s; return 0; end
         if (shadow_key[s] == k) begin where = s; return 1; end
      end
      return -1;
   endfunction

   function automatic void shift_out(int s);
      int hole;
      int si;
      int b;
      hole = s;
      for (int i = 1; i < SLOTS; i++) begin
         si = (s + i) % SLOTS;
         if (!shadow_valid[si]) break;
         b = home_slot(shadow_key[si]);
         if (((hole - b) & (SLOTS - 1)) <= ((si - b) & (SLOTS - 1))) begin
            shadow_key[hole] = shadow_key[si];
            shadow_val[hole] = shadow_val[si];
            hole = si;
         end
      end
      shadow_valid[hole] = 1'b0;
      if (shadow_count > 0) shadow_count--;
   endfunction

   function automatic table_reply_type apply_request(logic [2:0] kind, logic [63:0] k,
                                                     logic [31:0] v);
      table_reply_type r;
      int s;
      int hit;
      r.status    = ST_MISSING;
      r.value_out = '0;
      if (kind == KIND_CLEAR) begin
         foreach (shadow_valid[i]) shadow_valid[i] = 1'b0;
         shadow_count = 0;
         r.status = ST_FOUND;
      end else if (kind <= KIND_GOC) begin
         if (k == cfg_reserved) begin
            r.status = ST_RESERVED;
         end else begin
            hit = find_slot(k, s);
            if (kind == KIND_GET || kind == KIND_DEL) begin
               if (hit == 1) begin
                  r.status    = ST_FOUND;
                  r.value_out = shadow_val[s];
                  if (kind == KIND_DEL) shift_out(s);
               end
            end else if (hit == 1) begin
               if (kind == KIND_SET) shadow_val[s] = v;
               r.status    = ST_FOUND;
               r.value_out = shadow_val[s];
            end else if (hit == 0 && shadow_count < cfg_max) begin
               shadow_valid[s] = 1'b1;
               shadow_key[s]   = k;
               shadow_val[s]   = v;
               shadow_count++;
               r.status    = ST_INSERTED;
               r.value_out = v;
            end else begin
               r.status = ST_FULL;
            end
         end
      end
      r.entry_total = shadow_count[10:0];
      return r;
   endfunction

   function automatic bit want_idle();
      return ($urandom_range(99) < idle_pct);
   endfunction

   // one request item, predicted when accepted; valid stays up for the next one
   task automatic send_item(logic [2:0] kind, logic [63:0] k, logic [31:0] v);
      if (want_idle()) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while (want_idle()) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {v, k};
      do @(posedge clock); while (!req_tready);
      replies_due.push_back(apply_request(kind, k, v));
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (replies_due.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [63:0] d);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= d;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         REG_RESERVED: cfg_reserved = d;
         REG_BYPASS:   cfg_bypass   = d[0];
         REG_MAX:      cfg_max      = int'(d[9:0]);
         default: ;
      endcase
      @(posedge clock);
   endtask

   // response checker and ready stalls
   always @(posedge clock) begin
      table_reply_type got;
      table_reply_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[45:0];
            if (replies_due.size() == 0) begin
               $display("%0t: unexpected response %h", $realtime, rsp_tdata);
               fail_count++;
            end else begin
               want = replies_due.pop_front();
               if (got.status != want.status) begin
                  $display("%0t: status expected %0d actual %0d", $realtime,
                           want.status, got.status);
                  fail_count++;
               end
               if (got.value_out != want.value_out) begin
                  $display("%0t: value_out expected %h actual %h", $realtime,
                           want.value_out, got.value_out);
                  fail_count++;
               end
               if (got.entry_total != want.entry_total) begin
                  $display("%0t: entry_total expected %0d actual %0d", $realtime,
                           want.entry_total, got.entry_total);
                  fail_count++;
               end
            end
         end
         rsp_tready <= !want_idle();
      end
   end

   // watchdog on stalled progress
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic logic [63:0] rand_key();
      return {$urandom(), $urandom()};
   endfunction

   // extremes, every kind, reserved key, missing key, unknown kinds
   task automatic test_directed();
      send_item(KIND_GET, 64'h1, 32'h0);
      send_item(KIND_DEL, 64'h1, 32'h0);
      send_item(KIND_SET, 64'h0, 32'h5);            // reserved at reset
      send_item(KIND_SET, 64'hffff_ffff_ffff_ffff, 32'hffff_ffff);
      send_item(KIND_SET, 64'h1, 32'h0);
      send_item(KIND_GET, 64'hffff_ffff_ffff_ffff, 32'h0);
      send_item(KIND_SET, 64'h1, 32'h1234_5678);
      send_item(KIND_GOC, 64'h2, 32'haaaa_5555);
      send_item(KIND_GOC, 64'h2, 32'h1);
      send_item(KIND_DEL, 64'h1, 32'h0);
      send_item(KIND_GET, 64'h1, 32'h0);
      send_item(3'd5, 64'h2, 32'h0);
      send_item(3'd6, 64'h2, 32'h0);
      send_item(3'd7, 64'h2, 32'h0);
      send_item(KIND_GET, 64'h2, 32'h0);
      send_item(KIND_CLEAR, 64'hdead, 32'hbeef);
      send_item(KIND_GET, 64'h2, 32'h0);
      wait_drained();
   endtask

   // bypass mode: clustered keys force long probes and wrapped shifts
   task automatic test_bypass_clusters();
      logic [63:0] k;
      write_reg(REG_BYPASS, 64'h1);
      write_reg(REG_RESERVED, 64'hffff_ffff_ffff_ffff);
      write_reg(REG_MAX, 64'd1023);
      send_item(KIND_GOC, 64'h0, 32'h77);           // zero no longer reserved
      send_item(KIND_GET, 64'hffff_ffff_ffff_ffff, 32'h0);
      for (int i = 0; i < 300; i++) begin
         k = {52'($urandom_range(7)), 2'b00, 10'(1020 + $urandom_range(7))};
         case ($urandom_range(3))
            0, 1: send_item(KIND_SET, k, $urandom());
            2:    send_item(KIND_DEL, k, $urandom());
            default: send_item(KIND_GET, k, $urandom());
         endcase
      end
      wait_drained();
      write_reg(REG_BYPASS, 64'h0);                 // old homes, lookups may miss
      for (int i = 0; i < 20; i++) begin
         k = {52'($urandom_range(7)), 2'b00, 10'(1020 + $urandom_range(7))};
         send_item(KIND_GET, k, 32'h0);
      end
      send_item(KIND_CLEAR, 64'h0, 32'h0);
      wait_drained();
   endtask

   // tiny limit: full status, then the refused key after a delete
   task automatic test_full_limit();
      write_reg(REG_MAX, 64'd1);
      write_reg(REG_RESERVED, 64'h0);
      send_item(KIND_SET, 64'h10, 32'h1);
      send_item(KIND_SET, 64'h11, 32'h2);
      send_item(KIND_GOC, 64'h12, 32'h3);
      send_item(KIND_SET, 64'h10, 32'h4);
      send_item(KIND_DEL, 64'h10, 32'h0);
      send_item(KIND_SET, 64'h11, 32'h5);
      wait_drained();
      write_reg(REG_MAX, 64'd0);
      send_item(KIND_GOC, 64'h13, 32'h6);
      wait_drained();
      write_reg(REG_MAX, 64'd1023);
   endtask

   // random traffic over a reused key pool, with occasional clears
   task automatic test_random_traffic(int n);
      logic [63:0] k;
      logic [2:0]  kind;
      int          pick;
      for (int i = 0; i < 48; i++) key_pool.push_back(rand_key());
      key_pool.push_back(cfg_reserved);
      for (int i = 0; i < n; i++) begin
         idle_pct = (i >= n / 3 && i < n / 2) ? 0 : 29;
         k = ($urandom_range(9) == 0) ? rand_key()
                                      : key_pool[$urandom_range(key_pool.size() - 1)];
         pick = int'($urandom_range(99));
         if (pick < 35)      kind = KIND_SET;
         else if (pick < 60) kind = KIND_GET;
         else if (pick < 80) kind = KIND_DEL;
         else if (pick < 97) kind = KIND_GOC;
         else if (pick < 99) kind = KIND_CLEAR;
         else                kind = 3'($urandom_range(7, 5));
         send_item(kind, k, $urandom());
      end
      wait_drained();
   endtask

   initial begin
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tuser    = '0;
      req_tdata    = '0;
      csr_valid    = 1'b0;
      csr_index    = '0;
      csr_data     = '0;
      fail_count   = 0;
      idle_pct     = 29;
      shadow_count = 0;
      cfg_reserved = '0;
      cfg_bypass   = 1'b0;
      cfg_max      = 615;
      foreach (shadow_valid[i]) shadow_valid[i] = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_full_limit();
      test_bypass_clusters();
      write_reg(REG_MAX, 64'd30);
      test_random_traffic(400);
      write_reg(REG_MAX, 64'd615);
      write_reg(REG_RESERVED, key_pool[0]);
      test_random_traffic(800);

      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end
endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/lpht_pkg.sv
rtl/core/lpht_ram.sv
rtl/core/linear_probe_hash_table_core.sv
tb/sv/testbench.sv
